FILE: hw/rtl/hbx_pkg.sv
// ----------------------------------------------------------------------------
// hbx_pkg: shared types and constants of the three band crossover equalizer
// Holds the controller to datapath command and status structures.
// ----------------------------------------------------------------------------
package hbx_pkg;

  localparam int FAC_W     = 3;
  localparam int GAIN_W    = 16;
  localparam int STG_W     = 3;
  localparam int J_W       = 4;
  localparam int OUT_SHIFT = 22;

  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_TREBLE = 2'd1;
  localparam logic [1:0] REG_MID    = 2'd2;
  localparam logic [1:0] REG_BASS   = 2'd3;

  typedef enum logic [1:0] {
    MAC_BASS,
    MAC_MID,
    MAC_TREBLE
  } mac_sel_t;

  typedef struct packed {
    logic             load_dry;
    logic             wr;
    logic             acc_clr;
    logic             rd;
    logic [J_W-1:0]   j;
    logic             div_stage;
    logic             stage_end;
    logic             low;
    logic             div_smooth;
    logic             smooth_end;
    logic             bands;
    logic             mac;
    mac_sel_t         msel;
    logic             mclr;
    logic             chan_done;
    logic             out_load;
    logic             ch;
    logic [STG_W-1:0] stg;
  } hbx_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } hbx_stat_t;

endpackage

FILE: hw/rtl/three_band_hull_crossover_eq.sv
// ----------------------------------------------------------------------------
// three_band_hull_crossover_eq: stereo three band crossover equalizer
// Cascaded weighted moving averages split each channel into bass, mid and
// treble, which are mixed back with programmable gains.
// ----------------------------------------------------------------------------
// One stereo pair is processed at a time. Per channel each averaging stage
// costs one write, 4f history reads, a drain of the read pipe and a
// division by f (a shift for f of 1, 2 or 4; a reciprocal multiply for f of
// 3), each smoother costs that division, and the mixer forms the bands and
// takes three gain products. A stalled output holds the sequencer until the
// previous result is taken. The next pair is taken while the previous result
// still waits.
module three_band_hull_crossover_eq #(
  parameter int HISTORY_DEPTH  = 16,
  parameter int AVERAGE_STAGES = 3,
  parameter int SMOOTH_STAGES  = 3,
  parameter int SAMPLE_WIDTH   = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // sample_left, sample_right
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_left, out_right
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [hbx_pkg::GAIN_W-1:0]          cfg_data
);

  localparam int TDW     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int FAC_CAP = (HISTORY_DEPTH / 4 < 4) ? HISTORY_DEPTH / 4 : 4;

  logic [hbx_pkg::FAC_W-1:0]  oversample_factor;
  logic [hbx_pkg::GAIN_W-1:0] treble_gain;
  logic [hbx_pkg::GAIN_W-1:0] mid_gain;
  logic [hbx_pkg::GAIN_W-1:0] bass_gain;
  logic [hbx_pkg::FAC_W-1:0]  fac;
  logic                       in_take;
  hbx_pkg::hbx_cmd_t          cmd;
  hbx_pkg::hbx_stat_t         stat;
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversample_factor <= hbx_pkg::FAC_W'(1);
      treble_gain       <= hbx_pkg::GAIN_W'(16384);
      mid_gain          <= hbx_pkg::GAIN_W'(16384);
      bass_gain         <= hbx_pkg::GAIN_W'(16384);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hbx_pkg::REG_FACTOR: oversample_factor <= cfg_data[hbx_pkg::FAC_W-1:0];
        hbx_pkg::REG_TREBLE: treble_gain       <= cfg_data;
        hbx_pkg::REG_MID:    mid_gain          <= cfg_data;
        hbx_pkg::REG_BASS:   bass_gain         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (oversample_factor == '0) begin
      fac = hbx_pkg::FAC_W'(1);
    end else if (oversample_factor > hbx_pkg::FAC_W'(FAC_CAP)) begin
      fac = hbx_pkg::FAC_W'(FAC_CAP);
    end else begin
      fac = oversample_factor;
    end
  end

  assign in_take = s_tvalid && s_tready;
  assign m_tdata = TDW'({out_right, out_left});

  hbx_ctrl #(
    .AVERAGE_STAGES(AVERAGE_STAGES),
    .SMOOTH_STAGES (SMOOTH_STAGES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .fac     (fac),
    .stat    (stat),
    .cmd     (cmd)
  );

  hbx_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AVERAGE_STAGES(AVERAGE_STAGES),
    .SMOOTH_STAGES (SMOOTH_STAGES),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_take    (in_take),
    .in_left    ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
    .in_right   ($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .fac        (fac),
    .treble_gain(treble_gain),
    .mid_gain   (mid_gain),
    .bass_gain  (bass_gain),
    .cmd        (cmd),
    .stat       (stat),
    .out_left   (out_left),
    .out_right  (out_right)
  );

`ifndef SYNTHESIS
  a_take_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |-> !stat.div_busy)
    else $error("sample taken while divider busy");

  a_fac_range: assert property (@(posedge clk) disable iff (rst)
    (fac != '0) && (32'(fac) * 4 <= HISTORY_DEPTH))
    else $error("effective factor out of range");

  a_div_done_cause: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> ($past(stat.div_busy) || $past(cmd.div_stage || cmd.div_smooth)))
    else $error("divider done without a division");
`endif

endmodule

FILE: hw/rtl/hbx_div.sv
// ----------------------------------------------------------------------------
// hbx_div: floor division by the oversample factor
// Powers of two finish as a registered shift, a factor of three takes a
// reciprocal multiply on the following cycle.
// ----------------------------------------------------------------------------
module hbx_div #(
  parameter int DW = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DW-1:0]         num,
  input  logic [hbx_pkg::FAC_W-1:0]    fac,
  output logic                         busy,
  output logic                         done,
  output logic signed [DW-1:0]         quo
);

  localparam int MGW = DW - 1;
  // ceil(2^DW / 3), exact for magnitudes below 2^(DW-1)
  localparam logic [MGW-1:0] RECIP3 = MGW'(((longint'(1) <<< DW) + 2) / 3);

  logic             neg;
  logic [MGW-1:0]   mag;
  logic [MGW-1:0]   mag_r;
  logic [2*MGW-1:0] prod3;
  logic [MGW-1:0]   q3;

  // negative values divide as their complement, then complement back
  always_comb begin
    mag   = num[DW-1] ? ~num[DW-2:0] : num[DW-2:0];
    prod3 = mag_r * RECIP3;
    q3    = MGW'(prod3 >> DW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        neg   <= num[DW-1];
        mag_r <= mag;
        case (fac)
          3'd1: begin
            quo  <= num;
            done <= 1'b1;
          end
          3'd2: begin
            quo  <= num >>> 1;
            done <= 1'b1;
          end
          3'd4: begin
            quo  <= num >>> 2;
            done <= 1'b1;
          end
          default: begin
            busy <= 1'b1;
            done <= 1'b0;
          end
        endcase
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
        quo  <= neg ? $signed(~{1'b0, q3}) : $signed({1'b0, q3});
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/hbx_datapath.sv
// ----------------------------------------------------------------------------
// hbx_datapath: history memory, accumulators, smoothers and band mixer
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module hbx_datapath #(
  parameter int HISTORY_DEPTH  = 16,
  parameter int AVERAGE_STAGES = 3,
  parameter int SMOOTH_STAGES  = 3,
  parameter int SAMPLE_WIDTH   = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_take,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_left,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_right,
  input  logic [hbx_pkg::FAC_W-1:0]        fac,
  input  logic [hbx_pkg::GAIN_W-1:0]       treble_gain,
  input  logic [hbx_pkg::GAIN_W-1:0]       mid_gain,
  input  logic [hbx_pkg::GAIN_W-1:0]       bass_gain,
  input  hbx_pkg::hbx_cmd_t                cmd,
  output hbx_pkg::hbx_stat_t               stat,
  output logic signed [SAMPLE_WIDTH-1:0]   out_left,
  output logic signed [SAMPLE_WIDTH-1:0]   out_right
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int HW     = W + 4;
  localparam int BW     = W + 8;
  localparam int DW     = BW;
  localparam int SW     = HW + 3;
  localparam int NW     = SW + 5;
  localparam int PW     = $clog2(HISTORY_DEPTH);
  localparam int MDEPTH = AVERAGE_STAGES * 2 * HISTORY_DEPTH;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int SMN    = 2 * SMOOTH_STAGES;
  localparam int SMW    = $clog2(SMN);
  localparam int PRW    = BW + 1 + hbx_pkg::GAIN_W + 1;
  localparam int MW     = PRW + 2;

  localparam logic signed [DW-1:0]   V_MAX = DW'((longint'(1) <<< (HW - 1)) - 1);
  localparam logic signed [DW-1:0]   V_MIN = -V_MAX - DW'(1);
  localparam logic signed [BW:0]     Y_MAX = (BW+1)'((longint'(1) <<< (BW - 1)) - 1);
  localparam logic signed [BW:0]     Y_MIN = -Y_MAX - (BW+1)'(1);
  localparam logic signed [MW-1:0]   O_MAX = MW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [MW-1:0]   O_MIN = -O_MAX - MW'(1);
  localparam logic signed [MW-1:0]   O_RND = MW'(longint'(1) <<< (hbx_pkg::OUT_SHIFT - 1));

  logic [HW-1:0]         mem [MDEPTH];
  logic [MDEPTH-1:0]     mem_valid;
  logic [HW-1:0]         rd_data;
  logic                  rd_vld;
  logic                  rd_new;

  logic [PW-1:0]         wp;
  logic signed [W-1:0]   dry [2];
  logic signed [HW-1:0]  v;
  logic signed [SW-1:0]  sn;
  logic signed [SW-1:0]  so;
  logic signed [BW-1:0]  low;
  logic signed [BW-1:0]  bass;
  logic signed [BW-1:0]  y_reg;
  logic signed [BW-1:0]  sm [SMN];
  logic signed [BW:0]    mid;
  logic signed [BW:0]    treb;
  logic signed [PRW-1:0] prod;
  logic                  prod_vld;
  logic signed [MW-1:0]  macc;
  logic signed [W-1:0]   res [2];

  logic [PW:0]           idx_sum;
  logic [PW-1:0]         rd_idx;
  logic [MAW-1:0]        wr_addr;
  logic [MAW-1:0]        rd_addr;
  logic [SMW-1:0]        sidx;
  logic signed [NW-1:0]  sn_x;
  logic signed [NW-1:0]  so_x;
  logic signed [NW-1:0]  num_stage;
  logic signed [BW:0]    diff;
  logic signed [DW-1:0]  div_num;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic signed [DW-1:0]  quo;
  logic signed [HW-1:0]  v_sat;
  logic signed [BW:0]    ysum;
  logic signed [BW-1:0]  y_sat;
  logic signed [BW:0]    mop;
  logic [hbx_pkg::GAIN_W-1:0] mgain;
  logic signed [MW-1:0]  rnd;
  logic signed [W-1:0]   o_sat;

  always_comb begin
    idx_sum = {1'b0, wp} + (PW+1)'(cmd.j);
    if (idx_sum >= (PW+1)'(HISTORY_DEPTH)) begin
      rd_idx = PW'(idx_sum - (PW+1)'(HISTORY_DEPTH));
    end else begin
      rd_idx = idx_sum[PW-1:0];
    end
    wr_addr = MAW'((32'(cmd.stg) * 2 + 32'(cmd.ch)) * HISTORY_DEPTH + 32'(wp));
    rd_addr = MAW'((32'(cmd.stg) * 2 + 32'(cmd.ch)) * HISTORY_DEPTH + 32'(rd_idx));
    sidx    = SMW'(32'(cmd.stg) * 2 + 32'(cmd.ch));

    // (9 * newer - older + 8f) / 16, then the divider takes f
    sn_x      = NW'(sn);
    so_x      = NW'(so);
    num_stage = (sn_x <<< 3) + sn_x - so_x + $signed(NW'({fac, 3'b000}));
    diff      = (BW+1)'(bass) - (BW+1)'(sm[sidx]) + $signed((BW+1)'({fac, 2'b00}));
    div_start = cmd.div_stage | cmd.div_smooth;
    div_num   = cmd.div_smooth ? DW'(diff >>> 3) : DW'(num_stage >>> 4);

    if (quo > V_MAX) begin
      v_sat = V_MAX[HW-1:0];
    end else if (quo < V_MIN) begin
      v_sat = V_MIN[HW-1:0];
    end else begin
      v_sat = quo[HW-1:0];
    end

    ysum = (BW+1)'(y_reg) + (BW+1)'(quo);
    if (ysum > Y_MAX) begin
      y_sat = Y_MAX[BW-1:0];
    end else if (ysum < Y_MIN) begin
      y_sat = Y_MIN[BW-1:0];
    end else begin
      y_sat = ysum[BW-1:0];
    end

    case (cmd.msel)
      hbx_pkg::MAC_BASS: begin
        mop   = (BW+1)'(bass);
        mgain = bass_gain;
      end
      hbx_pkg::MAC_MID: begin
        mop   = mid;
        mgain = mid_gain;
      end
      hbx_pkg::MAC_TREBLE: begin
        mop   = treb;
        mgain = treble_gain;
      end
      default: begin
        mop   = '0;
        mgain = '0;
      end
    endcase

    rnd = (macc + O_RND) >>> hbx_pkg::OUT_SHIFT;
    if (rnd > O_MAX) begin
      o_sat = O_MAX[W-1:0];
    end else if (rnd < O_MIN) begin
      o_sat = O_MIN[W-1:0];
    end else begin
      o_sat = rnd[W-1:0];
    end
  end

  hbx_div #(
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .fac  (fac),
    .busy (div_busy),
    .done (div_done),
    .quo  (quo)
  );

  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;

  // history memory, entries never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= v;
    end
    rd_data <= mem_valid[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      wp        <= '0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
      for (int i = 0; i < SMN; i++) begin
        sm[i] <= '0;
      end
    end else begin
      rd_vld   <= cmd.rd;
      prod_vld <= cmd.mac;
      if (cmd.wr) begin
        mem_valid[wr_addr] <= 1'b1;
      end
      if (in_take) begin
        wp <= (wp == '0) ? PW'(HISTORY_DEPTH - 1) : wp - PW'(1);
      end
      if (cmd.smooth_end) begin
        sm[sidx] <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_new <= (5'(cmd.j) < 5'({fac, 1'b0}));
    if (in_take) begin
      dry[0] <= in_left;
      dry[1] <= in_right;
    end
    if (cmd.load_dry) begin
      v <= HW'(dry[cmd.ch]) <<< 4;
    end
    if (cmd.acc_clr) begin
      sn <= '0;
      so <= '0;
    end else if (rd_vld) begin
      if (rd_new) begin
        sn <= sn + SW'($signed(rd_data));
      end else begin
        so <= so + SW'($signed(rd_data));
      end
    end
    if (cmd.stage_end) begin
      v <= v_sat;
    end
    if (cmd.low) begin
      low  <= BW'(v) <<< 4;
      bass <= BW'(v) <<< 4;
    end
    if (cmd.div_smooth) begin
      y_reg <= sm[sidx];
    end
    if (cmd.smooth_end) begin
      bass <= y_sat;
    end
    if (cmd.bands) begin
      mid  <= (BW+1)'(low) - (BW+1)'(bass);
      treb <= ((BW+1)'(dry[cmd.ch]) <<< 8) - (BW+1)'(low);
    end
    if (cmd.mac) begin
      prod <= PRW'(mop) * $signed(PRW'({1'b0, mgain}));
    end
    if (cmd.mclr) begin
      macc <= '0;
    end else if (prod_vld) begin
      macc <= macc + MW'(prod);
    end
    if (cmd.chan_done) begin
      res[cmd.ch] <= o_sat;
    end
    if (cmd.out_load) begin
      out_left  <= res[0];
      out_right <= res[1];
    end
  end

endmodule

FILE: hw/rtl/hbx_ctrl.sv
// ----------------------------------------------------------------------------
// hbx_ctrl: sequencer of the three band crossover equalizer
// Steps both channels through the averaging stages, smoothers and mixer.
// ----------------------------------------------------------------------------
module hbx_ctrl #(
  parameter int AVERAGE_STAGES = 3,
  parameter int SMOOTH_STAGES  = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [hbx_pkg::FAC_W-1:0]     fac,
  input  hbx_pkg::hbx_stat_t            stat,
  output hbx_pkg::hbx_cmd_t             cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_WRITE,
    ST_READ,
    ST_TAIL,
    ST_WAIT_SD,
    ST_LOWS,
    ST_SMOOTH,
    ST_WAIT_SM,
    ST_BANDS,
    ST_MAC,
    ST_MTAIL,
    ST_OUT,
    ST_OUT2
  } state_t;

  state_t                      state;
  logic                        ch;
  logic [hbx_pkg::STG_W-1:0]   stg;
  logic [hbx_pkg::J_W-1:0]     j;
  logic [hbx_pkg::J_W-1:0]     j_last;

  assign s_tready = (state == ST_IDLE);
  assign j_last   = hbx_pkg::J_W'({fac, 2'b00} - 5'd1);

  always_ff @(posedge clk) begin
    hbx_pkg::hbx_cmd_t cmd_next;
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      ch       <= 1'b0;
      stg      <= '0;
      j        <= '0;
      cmd      <= '0;
    end else begin
      cmd_next     = '0;
      cmd_next.ch  = ch;
      cmd_next.stg = stg;
      cmd_next.j   = j;
      if (state == ST_OUT2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ch    <= 1'b0;
            stg   <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          cmd_next.load_dry = 1'b1;
          state             <= ST_WRITE;
        end
        ST_WRITE: begin
          cmd_next.wr      = 1'b1;
          cmd_next.acc_clr = 1'b1;
          j                <= '0;
          state            <= ST_READ;
        end
        ST_READ: begin
          cmd_next.rd = 1'b1;
          if (j == j_last) begin
            j     <= '0;
            state <= ST_TAIL;
          end else begin
            j <= j + hbx_pkg::J_W'(1);
          end
        end
        ST_TAIL: begin
          if (j == hbx_pkg::J_W'(1)) begin
            cmd_next.div_stage = 1'b1;
            state              <= ST_WAIT_SD;
          end else begin
            j <= j + hbx_pkg::J_W'(1);
          end
        end
        ST_WAIT_SD: begin
          if (stat.div_done) begin
            cmd_next.stage_end = 1'b1;
            if (stg == hbx_pkg::STG_W'(AVERAGE_STAGES - 1)) begin
              stg   <= '0;
              state <= ST_LOWS;
            end else begin
              stg   <= stg + hbx_pkg::STG_W'(1);
              state <= ST_WRITE;
            end
          end
        end
        ST_LOWS: begin
          cmd_next.low  = 1'b1;
          cmd_next.mclr = 1'b1;
          state         <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          cmd_next.div_smooth = 1'b1;
          state               <= ST_WAIT_SM;
        end
        ST_WAIT_SM: begin
          if (stat.div_done) begin
            cmd_next.smooth_end = 1'b1;
            if (stg == hbx_pkg::STG_W'(SMOOTH_STAGES - 1)) begin
              stg   <= '0;
              state <= ST_BANDS;
            end else begin
              stg   <= stg + hbx_pkg::STG_W'(1);
              state <= ST_SMOOTH;
            end
          end
        end
        ST_BANDS: begin
          cmd_next.bands = 1'b1;
          j              <= '0;
          state          <= ST_MAC;
        end
        ST_MAC: begin
          cmd_next.mac  = 1'b1;
          cmd_next.msel = hbx_pkg::mac_sel_t'(j[1:0]);
          if (j == hbx_pkg::J_W'(2)) begin
            j     <= '0;
            state <= ST_MTAIL;
          end else begin
            j <= j + hbx_pkg::J_W'(1);
          end
        end
        ST_MTAIL: begin
          if (j == hbx_pkg::J_W'(1)) begin
            cmd_next.chan_done = 1'b1;
            if (ch) begin
              state <= ST_OUT;
            end else begin
              ch    <= 1'b1;
              stg   <= '0;
              state <= ST_START;
            end
          end else begin
            j <= j + hbx_pkg::J_W'(1);
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            cmd_next.out_load = 1'b1;
            state             <= ST_OUT2;
          end
        end
        ST_OUT2: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      cmd <= cmd_next;
    end
  end

endmodule
